### src/clp_pkg.sv
// Shared types, constants and helper functions of the configuration line parser.
package clp_pkg;

  // Longest line the counters are sized for; counts saturate below it.
  localparam int unsigned LineMaxLen = 4096;
  localparam int unsigned CountW     = 12;
  localparam int unsigned CountCapInt =
      ((LineMaxLen - 1) < 4095) ? (LineMaxLen - 1) : 4095;
  localparam logic [CountW-1:0] CountCap = CountCapInt[CountW-1:0];

  // Configuration register.
  localparam int unsigned KeyLimitW    = 13;
  localparam logic [KeyLimitW-1:0] KeyLimitReset = 13'd256;
  localparam int unsigned AddrW        = 3;
  localparam logic RegIdxKeyLimit      = 1'b0;

  // Stream payload widths.
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 40;
  localparam int unsigned RoleW    = 2;

  // Characters with a special meaning.
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChSquote    = 8'h27;
  localparam logic [7:0] ChDquote    = 8'h22;
  localparam logic [7:0] ChHash      = 8'h23;
  localparam logic [7:0] ChEquals    = 8'h3D;
  localparam logic [7:0] ChSpace     = 8'h20;

  typedef enum logic [1:0] {
    ROLE_DROP  = 2'd0,
    ROLE_KEY   = 2'd1,
    ROLE_SEP   = 2'd2,
    ROLE_VALUE = 2'd3
  } role_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BLANK   = 2'd1,
    ST_NO_SEP  = 2'd2,
    ST_KEY_LONG = 2'd3
  } status_e;

  // Everything the step logic reports for one character.
  typedef struct packed {
    role_e             role;
    status_e           status;
    logic [CountW-1:0] key_length;
    logic              value_skip_first;
    logic [CountW-1:0] value_length;
  } clp_res_t;

  // Space, tab, newline, vertical tab, form feed and carriage return.
  function automatic logic is_ws(input logic [7:0] c);
    is_ws = (c == ChSpace) || (c inside {[8'h09:8'h0D]});
  endfunction

  function automatic logic is_quote(input logic [7:0] c);
    is_quote = (c == ChSquote) || (c == ChDquote);
  endfunction

endpackage

### src/config_line_parser_core.sv
// Top level of the configuration line parser: stream ports, register port, result register.
//
// The parser takes one character of a shell-style key=value line per transfer and returns
// one result per character, held in a single output register that is loaded on the transfer.
// A new character is taken in every cycle while the output side keeps up; s_axis_tready is
// low only when the output register holds a result that the sink has not yet taken. The
// result of the final character (tlast) carries the line verdict: status, key length,
// whether a leading quote is skipped and the value length. Write key_limit only while the
// block is idle; it is read back at address 0.
module config_line_parser_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Input stream.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [clp_pkg::InDataW-1:0]       s_axis_tdata,   // [7:0] in_byte
  input  logic                              s_axis_tlast,
  // Result stream.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [7:0] out_byte, [9:8] status, [21:10] key_length, [22] value_skip_first,
  // [34:23] value_length, [39:35] zero
  output logic [clp_pkg::OutDataW-1:0]      m_axis_tdata,
  output logic [clp_pkg::RoleW-1:0]         m_axis_tuser,   // [1:0] role
  output logic                              m_axis_tlast,
  // Register port.
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [clp_pkg::AddrW-1:0]         paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import clp_pkg::*;

  logic [KeyLimitW-1:0] key_limit_q;
  logic                 take;
  clp_res_t             res;
  logic                 ovalid_q;
  logic [7:0]           obyte_q;
  logic                 olast_q;
  clp_res_t             ores_q;

  // Register port: writes complete in the access cycle, no wait states.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegIdxKeyLimit) ?
                  {{(32-KeyLimitW){1'b0}}, key_limit_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_limit_q <= KeyLimitReset;
    end else if (psel && penable && pwrite && paddr[2] == RegIdxKeyLimit) begin
      key_limit_q <= pwdata[KeyLimitW-1:0];
    end
  end

  // Accept whenever the result register is free or being emptied this cycle.
  assign s_axis_tready = !ovalid_q || m_axis_tready;
  assign take          = s_axis_tvalid && s_axis_tready;

  clp_step u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .byte_i      (s_axis_tdata[7:0]),
    .last_i      (s_axis_tlast),
    .key_limit_i (key_limit_q),
    .res_o       (res)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (s_axis_tready) begin
      ovalid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      obyte_q <= s_axis_tdata[7:0];
      olast_q <= s_axis_tlast;
      ores_q  <= res;
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tlast  = olast_q;
  assign m_axis_tuser  = ores_q.role;
  assign m_axis_tdata  = {5'd0, ores_q.value_length, ores_q.value_skip_first,
                          ores_q.key_length, ores_q.status, obyte_q};

endmodule

### src/clp_step.sv
// Per-character line state: unescape, comment cut, key/value split and verdict.
module clp_step (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           take_i,
  input  logic [7:0]                     byte_i,
  input  logic                           last_i,
  input  logic [clp_pkg::KeyLimitW-1:0]  key_limit_i,
  output clp_pkg::clp_res_t              res_o
);
  import clp_pkg::*;

  logic              esc_q, esc_d;
  logic              sq_q, sq_d;
  logic              dq_q, dq_d;
  logic              ws_q, ws_d;
  logic              cut_q, cut_d;
  logic              text_q, text_d;
  logic              sep_q, sep_d;
  logic [CountW-1:0] key_q, key_d;
  logic [CountW-1:0] val_q, val_d;
  logic [CountW-1:0] kept_q, kept_d;
  logic              lastq_q, lastq_d;
  logic              firstq_q, firstq_d;

  logic              pass;
  logic              through;
  logic              sp;
  role_e             role;
  logic [CountW-1:0] kept;
  logic              skip;

  // Unescape, quote tracking and comment stages.
  always_comb begin
    esc_d   = esc_q;
    sq_d    = sq_q;
    dq_d    = dq_q;
    ws_d    = ws_q;
    cut_d   = cut_q;
    pass    = 1'b0;
    through = 1'b0;
    if (!cut_q) begin
      if (byte_i == ChBackslash && !esc_q) begin
        esc_d = 1'b1;
      end else begin
        esc_d = 1'b0;
        pass  = 1'b1;
      end
    end
    if (pass) begin
      through = 1'b1;
      if (sq_q && byte_i != ChSquote) begin
        through = 1'b1;
      end else if (dq_q && byte_i != ChDquote) begin
        through = 1'b1;
      end else if (byte_i == ChSquote) begin
        sq_d = ~sq_q;
        ws_d = 1'b0;
      end else if (byte_i == ChDquote) begin
        dq_d = ~dq_q;
        ws_d = 1'b0;
      end else if (byte_i == ChHash) begin
        if (ws_q) begin
          cut_d   = 1'b1;
          through = 1'b0;
        end
      end else begin
        ws_d = is_ws(byte_i);
      end
    end
  end

  // Parse stage: leading space skip, key, separator and value candidates.
  always_comb begin
    sp       = is_ws(byte_i);
    text_d   = text_q;
    sep_d    = sep_q;
    key_d    = key_q;
    val_d    = val_q;
    kept_d   = kept_q;
    lastq_d  = lastq_q;
    firstq_d = firstq_q;
    role     = ROLE_DROP;
    if (through && (text_q || !sp)) begin
      text_d = 1'b1;
      if (!sep_q) begin
        if (byte_i == ChEquals) begin
          sep_d = 1'b1;
          role  = ROLE_SEP;
        end else begin
          if (key_q < CountCap) begin
            key_d = key_q + 1'b1;
          end
          role = ROLE_KEY;
        end
      end else begin
        if (val_q == '0) begin
          firstq_d = is_quote(byte_i);
        end
        if (val_q < CountCap) begin
          val_d = val_q + 1'b1;
        end
        if (!sp) begin
          kept_d  = val_d;
          lastq_d = is_quote(byte_i);
        end
        role = ROLE_VALUE;
      end
    end
  end

  // Verdict of the whole line, shown on the final character only.
  always_comb begin
    kept = kept_d - {{(CountW-1){1'b0}}, (lastq_d && kept_d != '0)};
    skip = firstq_d && (kept != '0);
    res_o                  = '0;
    res_o.role             = role;
    res_o.status           = ST_OK;
    if (last_i) begin
      if (!text_d) begin
        res_o.status = ST_BLANK;
      end else if (!sep_d) begin
        res_o.status = ST_NO_SEP;
      end else if ({1'b0, key_d} >= key_limit_i) begin
        res_o.status     = ST_KEY_LONG;
        res_o.key_length = key_d;
      end else begin
        res_o.key_length       = key_d;
        res_o.value_skip_first = skip;
        res_o.value_length     = kept - {{(CountW-1){1'b0}}, skip};
      end
    end
  end

  // Line state advances on each transfer and clears after the final character.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q    <= 1'b0;
      sq_q     <= 1'b0;
      dq_q     <= 1'b0;
      ws_q     <= 1'b1;
      cut_q    <= 1'b0;
      text_q   <= 1'b0;
      sep_q    <= 1'b0;
      key_q    <= '0;
      val_q    <= '0;
      kept_q   <= '0;
      lastq_q  <= 1'b0;
      firstq_q <= 1'b0;
    end else if (take_i) begin
      if (last_i) begin
        esc_q    <= 1'b0;
        sq_q     <= 1'b0;
        dq_q     <= 1'b0;
        ws_q     <= 1'b1;
        cut_q    <= 1'b0;
        text_q   <= 1'b0;
        sep_q    <= 1'b0;
        key_q    <= '0;
        val_q    <= '0;
        kept_q   <= '0;
        lastq_q  <= 1'b0;
        firstq_q <= 1'b0;
      end else begin
        esc_q    <= esc_d;
        sq_q     <= sq_d;
        dq_q     <= dq_d;
        ws_q     <= ws_d;
        cut_q    <= cut_d;
        text_q   <= text_d;
        sep_q    <= sep_d;
        key_q    <= key_d;
        val_q    <= val_d;
        kept_q   <= kept_d;
        lastq_q  <= lastq_d;
        firstq_q <= firstq_d;
      end
    end
  end

endmodule

### src/clp_checker.sv
// Port-level checks of the configuration line parser and their binding to the top level.
module clp_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [clp_pkg::OutDataW-1:0]  m_axis_tdata,
  input logic [clp_pkg::RoleW-1:0]     m_axis_tuser,
  input logic                          m_axis_tlast
);
  import clp_pkg::*;

  // A stalled result keeps its valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result valid dropped while stalled");

  // A stalled result keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result payload changed while stalled");

  // Verdict fields and padding are zero except on the final character.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[39:8] == '0)
    else $error("verdict shown before end of line");

  // Value fields are reported only for a line that parsed cleanly.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast && m_axis_tdata[9:8] != ST_OK |->
      m_axis_tdata[34:22] == '0)
    else $error("value fields set on a failed line");

  // A blank line cannot end on a byte with a role, and reports no key length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast && m_axis_tdata[9:8] == ST_BLANK |->
      m_axis_tuser == ROLE_DROP && m_axis_tdata[21:10] == '0)
    else $error("blank line with key or role");

endmodule

bind config_line_parser_core clp_checker u_clp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
